>>> sv/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants for the chained hash set
// Table geometry, derived widths, result status codes and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package chs_pkg;

  // Table geometry
  localparam int MAX_BUCKETS      = 1024;
  localparam int SLOTS_PER_BUCKET = 8;
  localparam int MIN_BUCKETS      = 4;

  // Derived widths
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int CNT_W       = $clog2(MAX_BUCKETS) + 1;
  localparam int SLOT_W      = $clog2(SLOTS_PER_BUCKET);
  localparam int FILL_W      = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int SLOT_ADDR_W = BKT_W + SLOT_W;
  localparam int SLOT_DEPTH  = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int KEY_W       = 31;
  localparam int DATA_W      = 32;

  // Remainder unit: dividend bits retired per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_ITER  = (KEY_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DVD_W     = DIV_ITER * DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  // Result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NEGATIVE = 3'd3;
  localparam logic [2:0] ST_LOOKUP   = 3'd4;

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_en;
    logic load;
    logic div_step;
    logic fill_rd;
    logic scan_step;
    logic update;
    logic out_load;
  } chs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic key_neg;
    logic div_last;
    logic scan_done;
    logic out_free;
  } chs_sts_t;

endpackage

>>> sv/chs_ctrl.sv
// ----------------------------------------------------------------------------
// chs_ctrl: sequencing for the chained hash set
// Clears the fill counts after reset, then walks each word through remainder,
// fill read, bucket scan, table update (none for a negative key) and hand-off.
// ----------------------------------------------------------------------------
module chs_ctrl
  import chs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  chs_sts_t sts,
  output chs_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_FILL   = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_HOLD   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // Hold state; restart with the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decode state into commands and pick the next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.key_neg ? S_HOLD : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill_rd = 1'b1;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

>>> sv/chs_datapath.sv
// ----------------------------------------------------------------------------
// chs_datapath: storage and arithmetic for the chained hash set
// Bucket count register, iterative key remainder, fill-count memory, slot
// key and value memories, bucket scan and the output register.
// ----------------------------------------------------------------------------
module chs_datapath
  import chs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  chs_cmd_t          cmd,
  output chs_sts_t          sts,
  input  logic              opcode,
  input  logic signed [31:0] key,
  input  logic signed [31:0] item_value,
  input  logic              cfg_write_en,
  input  logic [CNT_W-1:0]  cfg_write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic [2:0]        status
);

  // Retire DIV_BITS dividend bits into the running remainder
  function automatic logic [CNT_W-1:0] div_digit(input logic [CNT_W-1:0] r_in,
                                                 input logic [DIV_BITS-1:0] bits,
                                                 input logic [CNT_W-1:0] dvs);
    logic [CNT_W-1:0] r;
    r = r_in;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      r = {r[CNT_W-2:0], bits[i]};
      if (r >= dvs) begin
        r = r - dvs;
      end
    end
    return r;
  endfunction

  logic [CNT_W-1:0]     bucket_count;
  logic [CNT_W-1:0]     bucket_count_next;
  logic [BKT_W-1:0]     clr_cnt;
  logic                 op_r;
  logic [KEY_W-1:0]     key_r;
  logic [DATA_W-1:0]    val_r;
  logic [DVD_W-1:0]     dvd;
  logic [CNT_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [BKT_W-1:0]     bucket;
  logic [FILL_W-1:0]    fill_q;
  logic [FILL_W-1:0]    iss;
  logic                 pend;
  logic                 hit;
  logic [KEY_W-1:0]     key_q;
  logic                 res_found;
  logic [2:0]           res_status;
  logic                 ins_write;
  logic                 fill_we;
  logic [BKT_W-1:0]     fill_waddr;
  logic [FILL_W-1:0]    fill_wdata;
  logic [SLOT_ADDR_W-1:0] slot_waddr;
  logic [SLOT_ADDR_W-1:0] slot_raddr;
  logic                 slot_rd;

  logic [FILL_W-1:0]    fill_mem [MAX_BUCKETS];
  logic [KEY_W-1:0]     key_mem  [SLOT_DEPTH];
  logic [DATA_W-1:0]    val_mem  [SLOT_DEPTH];

  // Clamp the written bucket count into the supported range
  always_comb begin
    if (cfg_write_data < CNT_W'(MIN_BUCKETS)) begin
      bucket_count_next = CNT_W'(MIN_BUCKETS);
    end else if (cfg_write_data > CNT_W'(MAX_BUCKETS)) begin
      bucket_count_next = CNT_W'(MAX_BUCKETS);
    end else begin
      bucket_count_next = cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= CNT_W'(MIN_BUCKETS);
    end else if (cfg_write_en) begin
      bucket_count <= bucket_count_next;
    end
  end

  // Sweep the fill counts to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      key_r <= key[KEY_W-1:0];
      val_r <= item_value;
    end
  end

  // Key remainder: DIV_BITS bits per cycle, most significant first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd     <= DVD_W'(key[KEY_W-1:0]);
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= div_digit(rem, dvd[DVD_W-1 -: DIV_BITS], bucket_count);
      dvd     <= dvd << DIV_BITS;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign bucket = rem[BKT_W-1:0];

  // Fill-count memory: one write port shared by clearing and insertion
  assign ins_write  = cmd.update && (op_r == OP_INSERT) && !hit &&
                      (fill_q < FILL_W'(SLOTS_PER_BUCKET));
  assign fill_we    = cmd.clear_en || ins_write;
  assign fill_waddr = cmd.clear_en ? clr_cnt : bucket;
  assign fill_wdata = cmd.clear_en ? '0 : fill_q + 1'b1;

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (cmd.fill_rd) begin
      fill_q <= fill_mem[bucket];
    end
  end

  // Slot memories: append on insert, read one slot per cycle during the scan
  assign slot_waddr = {bucket, fill_q[SLOT_W-1:0]};
  assign slot_raddr = {bucket, iss[SLOT_W-1:0]};
  assign slot_rd    = cmd.scan_step && (iss != fill_q);

  always_ff @(posedge clk) begin
    if (ins_write) begin
      key_mem[slot_waddr] <= key_r;
    end
    if (slot_rd) begin
      key_q <= key_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ins_write) begin
      val_mem[slot_waddr] <= val_r;
    end
  end

  // Scan: issue slot reads up to the fill count, compare each key once it is registered
  always_ff @(posedge clk) begin
    if (cmd.fill_rd) begin
      iss  <= '0;
      pend <= 1'b0;
      hit  <= 1'b0;
    end else if (cmd.scan_step) begin
      if (slot_rd) begin
        iss  <= iss + 1'b1;
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
      if (pend && (key_q == key_r)) begin
        hit <= 1'b1;
      end
    end
  end

  // Form the result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_found  <= 1'b0;
      res_status <= ST_NEGATIVE;
    end else if (cmd.update) begin
      priority if (op_r == OP_LOOKUP) begin
        res_found  <= hit;
        res_status <= ST_LOOKUP;
      end else if (hit) begin
        res_found  <= 1'b1;
        res_status <= ST_PRESENT;
      end else if (fill_q >= FILL_W'(SLOTS_PER_BUCKET)) begin
        res_found  <= 1'b0;
        res_status <= ST_FULL;
      end else begin
        res_found  <= 1'b0;
        res_status <= ST_INSERTED;
      end
    end
  end

  // Output register: load when free, drop valid once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found  <= res_found;
      status <= res_status;
    end
  end

  // Status to the controller
  assign sts.clear_last = (clr_cnt == BKT_W'(MAX_BUCKETS - 1));
  assign sts.key_neg    = key[31];
  assign sts.div_last   = (div_cnt == DIV_CNT_W'(DIV_ITER - 1));
  assign sts.scan_done  = (iss == fill_q) && !pend;
  assign sts.out_free   = !out_valid || !out_stall;

  // Remainder stays below the modulus after every step
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (rem < bucket_count))
    else $error("remainder not below bucket count");

  // Fill counts read back within the bucket capacity
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (fill_q <= FILL_W'(SLOTS_PER_BUCKET)))
    else $error("fill count beyond bucket capacity");

  // Scan never reads past the filled slots
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (iss <= fill_q))
    else $error("scan index beyond fill count");

  // A new result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten");

endmodule

>>> sv/chained_hash_set_insert_lookup.sv
// ----------------------------------------------------------------------------
// chained_hash_set_insert_lookup: integer-key hash set with bucket chaining
// Inserts or looks up non-negative keys in buckets chosen by key modulo the
// configured bucket count; eight slots per bucket, one result per word.
// ----------------------------------------------------------------------------
// After reset the block clears the fill counts of all 1024 buckets and holds
// in_stall high meanwhile; bucket_count writes are taken during that time. It
// then works on one word at a time. A word with a non-negative key passes
// through the key remainder at 4 bits per cycle, the fill count read, a bucket
// scan that reads one slot per cycle from the single read port of the key
// memory, and the table update. A negative key goes straight from acceptance
// to the result hand-off. A finished result sits in an output register, so the
// next word is accepted while it waits to be taken.
module chained_hash_set_insert_lookup
  import chs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [31:0] key,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic [2:0]         status,
  input  logic               cfg_write_en,
  input  logic [CNT_W-1:0]   cfg_write_data
);

  chs_cmd_t cmd;
  chs_sts_t sts;

  // Sequencer
  chs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  chs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (opcode),
    .key            (key),
    .item_value     (item_value),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .status         (status)
  );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for chained_hash_set_insert_lookup
// Drives insert and lookup words through the valid/stall handshake, tracks the
// bucket contents in a scoreboard and checks every result word in order. The
// bucket count is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench
  import chs_pkg::*;
();

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 80;
  localparam int GAP_PERCENT   = 13;
  localparam int KEY_HISTORY   = 64;

  typedef struct packed {
    logic       found;
    logic [2:0] status;
  } outcome_t;

  // Mirror of the bucket table and queue of outcomes still to arrive
  class hash_set_scoreboard;
    int unsigned      modulus;
    int unsigned      fill_count[MAX_BUCKETS];
    logic [KEY_W-1:0] stored_keys[SLOT_DEPTH];
    outcome_t         awaited[$];
    int               errors;

    function new();
      modulus = MIN_BUCKETS;
      errors  = 0;
      foreach (fill_count[i]) fill_count[i] = 0;
    endfunction

    // Clamp the written count into the legal bucket range
    function void set_bucket_count(logic [CNT_W-1:0] raw);
      if (raw < MIN_BUCKETS) modulus = MIN_BUCKETS;
      else if (raw > MAX_BUCKETS) modulus = MAX_BUCKETS;
      else modulus = raw;
    endfunction

    // Work out the outcome of an accepted word and update the table
    function void note_word(logic op, logic [31:0] k);
      outcome_t         o;
      logic [KEY_W-1:0] kk;
      int unsigned      bkt;
      bit               hit;
      o.found = 1'b0;
      if (k[31]) begin
        o.status = ST_NEGATIVE;
      end else begin
        kk  = k[KEY_W-1:0];
        bkt = kk % modulus;
        hit = 1'b0;
        for (int i = 0; i < fill_count[bkt]; i++) begin
          if (stored_keys[bkt * SLOTS_PER_BUCKET + i] == kk) hit = 1'b1;
        end
        if (op == OP_LOOKUP) begin
          o.found  = hit;
          o.status = ST_LOOKUP;
        end else if (hit) begin
          o.found  = 1'b1;
          o.status = ST_PRESENT;
        end else if (fill_count[bkt] >= SLOTS_PER_BUCKET) begin
          o.status = ST_FULL;
        end else begin
          stored_keys[bkt * SLOTS_PER_BUCKET + fill_count[bkt]] = kk;
          fill_count[bkt]++;
          o.status = ST_INSERTED;
        end
      end
      awaited.push_back(o);
    endfunction

    // Compare a result word with the oldest outcome
    function void check_result(logic f, logic [2:0] st);
      outcome_t o;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing awaited, actual found %0d status %0d",
                 $time, f, st);
        errors++;
      end else begin
        o = awaited.pop_front();
        if (f !== o.found) begin
          $display("%0t: found mismatch, expected %0d, actual %0d", $time, o.found, f);
          errors++;
        end
        if (st !== o.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time, o.status, st);
          errors++;
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               opcode;
  logic signed [31:0] key;
  logic signed [31:0] item_value;
  logic               out_valid;
  logic               out_stall;
  logic               found;
  logic [2:0]         status;
  logic               cfg_write_en;
  logic [CNT_W-1:0]   cfg_write_data;

  hash_set_scoreboard sb = new();
  bit                 gaps_enabled = 1'b1;
  bit                 hold_request = 1'b0;
  logic [31:0]        known_keys[$];

  chained_hash_set_insert_lookup i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .key            (key),
    .item_value     (item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one word, idling at random first; return at the accepting edge
  task automatic send_word(input logic op, input logic [31:0] k, input logic [31:0] v);
    while (gaps_enabled && $urandom_range(0, 99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    key        <= k;
    item_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op, k);
    if (op == OP_INSERT && !k[31]) begin
      known_keys.push_back(k);
      if (known_keys.size() > KEY_HISTORY) void'(known_keys.pop_front());
    end
  endtask

  // Stop sending and hold until every outcome has arrived
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [CNT_W-1:0] raw);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= raw;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_bucket_count(raw);
    @(posedge clk);
  endtask

  // Mostly colliding keys in a few busy buckets, plus repeats, negatives and wide keys
  task automatic random_words(input int count);
    logic        op;
    logic [31:0] k;
    int unsigned pick;
    int unsigned home;
    for (int n = 0; n < count; n++) begin
      op   = ($urandom_range(0, 99) < 60) ? OP_INSERT : OP_LOOKUP;
      pick = $urandom_range(0, 99);
      home = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sb.modulus - 1)
                                         : $urandom_range(0, 5);
      if (pick < 8) k = {1'b1, 31'($urandom())};
      else if (pick < 30 && known_keys.size() > 0)
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else if (pick < 85) k = 32'(home + sb.modulus * $urandom_range(0, 11));
      else k = {1'b0, 31'($urandom())};
      send_word(op, k, $urandom());
    end
  endtask

  // Result side: take words, stall at random, and hold off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(found, status);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_enabled && ($urandom_range(0, 99) < GAP_PERCENT);
      end
    end
  end

  // End the run when no word moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    opcode         <= OP_INSERT;
    key            <= '0;
    item_value     <= '0;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill bucket zero under the reset count, then overflow and repeats
    for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
      send_word(OP_INSERT, 32'(4 * i),
                (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7FFF_FFFF :
                (i == 2) ? 32'hFFFF_FFFF : 32'(i));
    end
    send_word(OP_INSERT, 32'd32, 32'd0);
    send_word(OP_INSERT, 32'd12, 32'd5);
    send_word(OP_LOOKUP, 32'd28, 32'd0);
    send_word(OP_LOOKUP, 32'd32, 32'hFFFF_FFFF);
    send_word(OP_LOOKUP, 32'd1, 32'd0);
    send_word(OP_INSERT, 32'h8000_0000, 32'd7);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0);
    send_word(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OP_LOOKUP, 32'h7FFF_FFFF, 32'd0);
    send_word(OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    wait_for_results();

    // Count below the minimum clamps; receiver holds off while words keep coming
    write_bucket_count(11'd0);
    hold_request = 1'b1;
    random_words(100);
    wait_for_results();

    // Count above the maximum clamps
    write_bucket_count(11'h7FF);
    random_words(120);
    wait_for_results();

    // Odd small count with no idling on either side
    write_bucket_count(11'd5);
    gaps_enabled = 1'b0;
    random_words(130);
    wait_for_results();
    gaps_enabled = 1'b1;

    write_bucket_count(11'd1024);
    random_words(100);
    wait_for_results();

    write_bucket_count(11'd3);
    random_words(100);
    wait_for_results();

    write_bucket_count(11'd1023);
    random_words(100);
    wait_for_results();

    write_bucket_count(11'($urandom_range(4, 64)));
    random_words(100);
    wait_for_results();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> sim.f
sv/chs_pkg.sv
sv/chs_ctrl.sv
sv/chs_datapath.sv
sv/chained_hash_set_insert_lookup.sv
verif/testbench.sv
